// ===== src/sha256_stream_hasher_assert.svh =====
// Assertion macros for the SHA-256 stream hasher.
// Used by the top level only; no other dependencies.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/sha_pkg.sv =====
// Shared types and constants for the SHA-256 stream hasher.
// No dependencies.
package sha_pkg;
    localparam int unsigned CntW = 61;

    typedef enum logic [2:0] {
        ST_LOAD, ST_PAD, ST_ROUND, ST_ADD, ST_OUT
    } t_state;

    // Request from sequencer to round unit.
    typedef struct packed {
        logic start;   // load working vars from hash state
        logic step;    // run one round
        logic add;     // add working vars into hash state
        logic init;    // restore initial value
    } t_rnd_ctl;

    function automatic logic [31:0] init_h(input logic [2:0] i);
        case (i)
            3'd0: init_h = 32'h6a09e667;
            3'd1: init_h = 32'hbb67ae85;
            3'd2: init_h = 32'h3c6ef372;
            3'd3: init_h = 32'ha54ff53a;
            3'd4: init_h = 32'h510e527f;
            3'd5: init_h = 32'h9b05688c;
            3'd6: init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
              32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
              32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
              32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
              32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
              32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
              32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
              32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
              32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
              32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
              32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
              32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
              32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage

// ===== src/sha256_stream_hasher.sv =====
// Channel | dir | tdata bits                          | tuser      | tlast
// s_axis  | in  | [7:0] data_byte                     | has_byte   | end_of_message
// m_axis  | out | [31:0] digest_word, [34:32] word_index (zero filled to 40) | - | last_word
// Bytes are accepted in ST_LOAD; the byte that completes a block is followed by the
// rounds and the add with s_axis_tready low, so no new byte is taken before the add.
// At message end padding shifts in one byte per cycle (64 - fill, or 64 for a
// length-only block), then the rounds and add per block; two blocks when more than 55
// bytes are pending. Digest goes out over 8 requests, each waiting on m_axis_tready;
// s_axis_tready stays low meanwhile. Reset is synchronous, active low, restores the IV.
// Depends on sha_pkg, sha_sched, sha_round and the assertion header.
`include "sha256_stream_hasher_assert.svh"
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);
    t_state      r_state, n_state;
    logic [CntW-1:0] r_cnt;
    logic [31:0] r_acc;
    logic [5:0]  r_rnd;        // round or pad byte position
    logic        r_eom, r_lenblk;
    logic        r_pad;        // current message end has entered padding
    logic [2:0]  r_oidx;
    t_rnd_ctl    ctl;
    logic        sch_load;
    logic [31:0] sch_word, w_cur, h_sel;
    logic        acc_in, take;
    logic [7:0]  pbyte;
    logic [63:0] bits;
    logic [5:0]  fill;

    assign take   = s_axis_tvalid && s_axis_tready;
    assign fill   = r_cnt[5:0];
    assign bits   = {r_cnt, 3'b000};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (take && s_axis_tuser && fill == 6'd63) n_state = ST_ROUND;
                else if (take && s_axis_tlast) n_state = ST_PAD;
            end
            ST_PAD:   if (r_rnd == 6'd63) n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == 6'd63) n_state = ST_ADD;
            ST_ADD: begin
                if (!r_eom) n_state = ST_LOAD;
                else if (r_pad && (r_lenblk || fill <= 6'd55)) n_state = ST_OUT;
                else n_state = ST_PAD;
            end
            ST_OUT:   if (m_axis_tready && r_oidx == 3'd7) n_state = ST_LOAD;
            default:  n_state = ST_LOAD;
        endcase
    end

    // Padding byte at position r_rnd of the current padded block
    always_comb begin
        pbyte = 8'h00;
        if (!r_lenblk && r_rnd == fill) pbyte = 8'h80;
        else if (r_rnd >= 6'd56 && (r_lenblk || fill <= 6'd55))
            pbyte = bits[8 * (63 - r_rnd) +: 8];
    end

    // Outputs and unit control
    always_comb begin
        s_axis_tready = (r_state == ST_LOAD);
        m_axis_tvalid = (r_state == ST_OUT);
        acc_in   = (r_state == ST_PAD) && (r_lenblk || r_rnd >= fill);
        sch_load = 1'b0;
        sch_word = {r_acc[23:0], pbyte};
        ctl      = '0;
        ctl.step = (r_state == ST_ROUND);
        ctl.add  = (r_state == ST_ADD);
        ctl.init = (r_state == ST_OUT) && m_axis_tready && r_oidx == 3'd7;
        if (r_state == ST_LOAD && take && s_axis_tuser && fill[1:0] == 2'd3) begin
            sch_load = 1'b1;
            sch_word = {r_acc[23:0], s_axis_tdata};
        end else if (r_state == ST_PAD && r_rnd[1:0] == 2'd3 && acc_in) begin
            sch_load = 1'b1;
        end
        ctl.start = (r_state != ST_ROUND) && (n_state == ST_ROUND);
    end

    assign m_axis_tdata = {5'd0, r_oidx, h_sel};
    assign m_axis_tlast = (r_oidx == 3'd7);

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_rnd   <= '0;
            r_eom   <= 1'b0;
            r_lenblk <= 1'b0;
            r_pad   <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_LOAD: begin
                    r_rnd <= '0;
                    if (take) begin
                        if (s_axis_tuser) r_cnt <= r_cnt + 1'b1;
                        r_eom <= s_axis_tlast;
                        r_lenblk <= 1'b0;
                        r_pad <= 1'b0;
                        if (s_axis_tlast && !(s_axis_tuser && fill == 6'd63))
                            r_rnd <= s_axis_tuser ? fill + 6'd1 : fill;
                    end
                end
                ST_PAD: begin
                    r_rnd <= r_rnd + 6'd1;
                    r_pad <= 1'b1;
                end
                ST_ROUND: r_rnd <= r_rnd + 6'd1;
                ST_ADD: begin
                    r_rnd <= '0;
                    // Length spills into a second block when the pad byte sat past 55
                    if (r_eom && r_pad && !r_lenblk && fill > 6'd55) r_lenblk <= 1'b1;
                    if (n_state == ST_OUT) r_oidx <= '0;
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) r_cnt <= '0;
                    end
                end
                default: r_rnd <= '0;
            endcase
        end
    end

    // Byte accumulator for block words
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && take && s_axis_tuser) r_acc <= {r_acc[23:0], s_axis_tdata};
        else if (acc_in) r_acc <= {r_acc[23:0], pbyte};
    end

    sha_sched u_sched (
        .i_clk  (i_clk),
        .i_load (sch_load),
        .i_word (sch_word),
        .i_step (r_state == ST_ROUND),
        .o_w    (w_cur)
    );

    sha_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_rnd   (r_rnd),
        .i_w     (w_cur),
        .i_sel   (r_oidx),
        .o_h     (h_sel)
    );

    `SHA_ASSERT_IMP(a_excl, m_axis_tvalid, !s_axis_tready, "accept while emitting")
    `SHA_ASSERT_NEXT(a_last, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        r_state == ST_LOAD && r_cnt == '0, "no return to load after digest")
    `SHA_ASSERT_IMP(a_rnd, r_state == ST_ADD, r_rnd == '0, "round count not wrapped")
endmodule

// ===== src/sha_sched.sv =====
// Message schedule: 16-word sliding window, fed by block words on load and one new word per round.
// Depends on sha_pkg.
module sha_sched
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,    // shift in a block word
    input  logic [31:0] i_word,
    input  logic        i_step,    // advance one round
    output logic [31:0] o_w        // word for the current round
);
    logic [31:0] r_w [16];
    logic [31:0] s0, s1, wn;

    always_comb begin
        s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        wn = r_w[0] + s0 + r_w[9] + s1;
    end
    assign o_w = r_w[0];

    // Shift the window on load or round
    always_ff @(posedge i_clk) begin
        if (i_load || i_step) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= i_load ? i_word : wn;
        end
    end
endmodule

// ===== src/sha_round.sv =====
// Shared SHA-256 round unit and the 8-word hash state.
// Depends on sha_pkg.
module sha_round
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rnd_ctl    i_ctl,
    input  logic [5:0]  i_rnd,
    input  logic [31:0] i_w,
    input  logic [2:0]  i_sel,
    output logic [31:0] o_h
);
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] t1, t2, e, a;

    always_comb begin
        e  = r_v[4];
        a  = r_v[0];
        t1 = r_v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
           + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(i_rnd) + i_w;
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
           + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end
    assign o_h = r_h[i_sel];

    // Hash state: initial value, or fold in the working variables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
        end else if (i_ctl.add) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    // Working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_ctl.step) begin
            for (int i = 1; i < 8; i++) r_v[i] <= r_v[i - 1];
            r_v[4] <= r_v[3] + t1;
            r_v[0] <= t1 + t2;
        end
    end
endmodule
